// ----- rtl/sfrsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfrsc_pkg
// Shared widths, reset values and beat types of the frame receiver.
// ----------------------------------------------------------------------------
package sfrsc_pkg;

	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 6;

	localparam logic [BYTE_W-1:0] START_RESET = 8'hC1;

	// frame buffer selector: the store holds two frames
	typedef logic buf_id_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  frame_byte;
		logic [INDEX_W-1:0] byte_index;
		logic               frame_last;
	} frame_beat_t;

endpackage : sfrsc_pkg
`default_nettype wire

// ----- rtl/sfrsc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfrsc channel interfaces
// Valid/ready channels for received bytes, checked frame beats and the
// start byte register write.
// ----------------------------------------------------------------------------
interface sfrsc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface : sfrsc_rx_if

interface sfrsc_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic [5:0] byte_index;
	logic       frame_last;

	modport source (output valid, output frame_byte, output byte_index,
		output frame_last, input ready);
	modport sink   (input valid, input frame_byte, input byte_index,
		input frame_last, output ready);
endinterface : sfrsc_frame_if

interface sfrsc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] start_byte;

	modport source (output valid, output start_byte, input ready);
	modport sink   (input valid, input start_byte, output ready);
endinterface : sfrsc_cfg_if
`default_nettype wire

// ----- rtl/sync_frame_receiver_sum_check_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_receiver_sum_check_unit
// Fixed-length frame receiver with an additive checksum and a double
// buffered frame store.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat carries                              handshake
//  -------  ---  ----------------------------------------  -----------
//  rx       in   rx_byte                                   valid/ready
//  frame    out  frame_byte, byte_index, frame_last        valid/ready
//  cfg      in   start_byte (always ready)                 valid/ready
//
//  Takes one rx beat per cycle while a frame buffer is free. A frame that
//  passes its sum leaves FRAME_LEN beats after its last byte, one per
//  cycle while the frame channel is ready; the drain of one buffer overlaps
//  the fill of the other. rx stalls only while both buffers wait to be drained.
//  Reset clears all control state; the store needs no clearing pass.
//  A stalled frame channel holds its beat and backs up into the store.
//
module sync_frame_receiver_sum_check_unit import sfrsc_pkg::*; #(
	parameter int FRAME_LEN = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sfrsc_rx_if.sink      rx,
	sfrsc_frame_if.source frame,
	sfrsc_cfg_if.sink     cfg
);

	localparam int ADDR_W = $clog2(FRAME_LEN) + 1;
	localparam int DEPTH  = 2 ** ADDR_W;

	logic [BYTE_W-1:0] start_byte_q;
	logic              buf_free;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              push_valid;
	buf_id_t           push_buf;
	logic              q_pop;
	logic              q_valid;
	buf_id_t           q_buf;
	logic [1:0]        q_count;
	logic              back_active;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [BYTE_W-1:0] rd_data;
	frame_beat_t       out_beat;

	// Register write: take every beat at once.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_RESET;
		end else if (cfg.valid) begin
			start_byte_q <= cfg.start_byte;
		end
	end

	// A buffer is owned by the drain side from its push until its last read
	// issues. Accept rx only while the fill side's buffer is not among them.
	assign buf_free = ({1'b0, q_count} + {2'b00, back_active}) < 3'd2;

	sfrsc_front #(
		.FRAME_LEN (FRAME_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rx.valid),
		.in_byte    (rx.rx_byte),
		.in_ready   (rx.ready),
		.start_byte (start_byte_q),
		.buf_free   (buf_free),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.push_valid (push_valid),
		.push_buf   (push_buf)
	);

	// Frame store: two buffers, each padded to a power of two.
	sfrsc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	sfrsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_buf   (push_buf),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_buf   (q_buf),
		.count      (q_count)
	);

	sfrsc_back #(
		.FRAME_LEN (FRAME_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_buf   (q_buf),
		.pop        (q_pop),
		.active     (back_active),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_valid  (frame.valid),
		.out_beat   (out_beat),
		.out_ready  (frame.ready)
	);

	// Drive the output beat fields.
	assign frame.frame_byte = out_beat.frame_byte;
	assign frame.byte_index = out_beat.byte_index;
	assign frame.frame_last = out_beat.frame_last;

endmodule : sync_frame_receiver_sum_check_unit
`default_nettype wire

// ----- rtl/sfrsc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfrsc_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sfrsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : sfrsc_ram
`default_nettype wire

// ----- rtl/sfrsc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfrsc_front
// Hunt for the start byte, fill the current buffer, check the sum.
// ----------------------------------------------------------------------------
module sfrsc_front import sfrsc_pkg::*; #(
	parameter int FRAME_LEN = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic [BYTE_W-1:0]            in_byte,
	output logic                              in_ready,
	input  wire logic [BYTE_W-1:0]            start_byte,
	input  wire logic                         buf_free,
	output logic                              wr_en,
	output logic [$clog2(FRAME_LEN):0]        wr_addr,
	output logic [BYTE_W-1:0]                 wr_data,
	output logic                              push_valid,
	output buf_id_t                           push_buf
);

	localparam int IDX_W = $clog2(FRAME_LEN);

	typedef enum logic [1:0] {
		ST_HUNT = 2'b01,
		ST_FILL = 2'b10
	} front_state_t;

	front_state_t      state_q;
	logic [IDX_W-1:0]  fill_q;
	logic [BYTE_W-1:0] sum_q;
	buf_id_t           wbuf_q;
	logic              accept;
	logic              at_last;
	logic              start_hit;

	assign in_ready  = buf_free;
	assign accept    = in_valid && in_ready;
	assign at_last   = (fill_q == IDX_W'(FRAME_LEN - 1));
	assign start_hit = (in_byte == start_byte);
	assign wr_addr   = {wbuf_q, fill_q};
	assign wr_data   = in_byte;
	assign push_buf  = wbuf_q;

	always_comb begin
		wr_en      = 1'b0;
		push_valid = 1'b0;
		if (accept) begin
			unique case (state_q)
				ST_HUNT: begin
					wr_en = start_hit;
				end
				ST_FILL: begin
					wr_en      = 1'b1;
					push_valid = at_last && (sum_q == in_byte);
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			fill_q  <= '0;
			sum_q   <= '0;
			wbuf_q  <= 1'b0;
		end else if (accept) begin
			unique case (state_q)
				ST_HUNT: begin
					// fill_q is zero while hunting, so the start byte lands at entry 0
					if (start_hit) begin
						state_q <= ST_FILL;
						fill_q  <= IDX_W'(1);
						sum_q   <= in_byte;
					end
				end
				ST_FILL: begin
					if (at_last) begin
						state_q <= ST_HUNT;
						fill_q  <= '0;
						sum_q   <= '0;
						if (push_valid) begin
							wbuf_q <= ~wbuf_q;
						end
					end else begin
						fill_q <= fill_q + IDX_W'(1);
						sum_q  <= sum_q + in_byte;
					end
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

endmodule : sfrsc_front
`default_nettype wire

// ----- rtl/sfrsc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfrsc_queue
// Two-entry queue of checked buffers waiting for the drain side.
// ----------------------------------------------------------------------------
module sfrsc_queue import sfrsc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire buf_id_t push_buf,
	input  wire logic    pop,
	output logic         head_valid,
	output buf_id_t      head_buf,
	output logic [1:0]   count
);

	buf_id_t    slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign head_valid = (count_q != 2'd0);
	assign head_buf   = slot_q[rptr_q];
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_buf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule : sfrsc_queue
`default_nettype wire

// ----- rtl/sfrsc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfrsc_back
// Drain one checked buffer from the store into a two-beat output queue.
// ----------------------------------------------------------------------------
module sfrsc_back import sfrsc_pkg::*; #(
	parameter int FRAME_LEN = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   head_valid,
	input  wire buf_id_t                head_buf,
	output logic                        pop,
	output logic                        active,
	output logic                        rd_en,
	output logic [$clog2(FRAME_LEN):0]  rd_addr,
	input  wire logic [BYTE_W-1:0]      rd_data,
	output logic                        out_valid,
	output frame_beat_t                 out_beat,
	input  wire logic                   out_ready
);

	localparam int IDX_W = $clog2(FRAME_LEN);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} back_state_t;

	back_state_t      state_q;
	buf_id_t          rbuf_q;
	logic [IDX_W-1:0] pos_q;
	logic             rd_s1;
	logic [IDX_W-1:0] pos_s1;
	logic             last_s1;
	frame_beat_t      obuf_q [2];
	logic             owptr_q;
	logic             orptr_q;
	logic [1:0]       ocount_q;
	logic             opop;
	logic [2:0]       committed;
	logic             pos_last;

	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign active   = (state_q == ST_EMIT);
	assign pos_last = (pos_q == IDX_W'(FRAME_LEN - 1));
	assign rd_addr  = {rbuf_q, pos_q};

	assign out_valid = (ocount_q != 2'd0);
	assign out_beat  = obuf_q[orptr_q];
	assign opop      = out_valid && out_ready;

	// slots already spoken for after this edge: queued beats plus a read in flight
	assign committed = {1'b0, ocount_q} + {2'b00, rd_s1} - {2'b00, opop};
	assign rd_en     = active && (committed < 3'd2);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pos_s1  <= pos_q;
			last_s1 <= pos_last;
		end
		if (rd_s1) begin
			obuf_q[owptr_q] <= '{frame_byte: rd_data,
				byte_index: INDEX_W'(pos_s1), frame_last: last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rbuf_q   <= 1'b0;
			pos_q    <= '0;
			rd_s1    <= 1'b0;
			owptr_q  <= 1'b0;
			orptr_q  <= 1'b0;
			ocount_q <= 2'd0;
		end else begin
			rd_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						state_q <= ST_EMIT;
						rbuf_q  <= head_buf;
						pos_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (rd_en) begin
						pos_q <= pos_q + IDX_W'(1);
						if (pos_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (rd_s1) begin
				owptr_q <= ~owptr_q;
			end
			if (opop) begin
				orptr_q <= ~orptr_q;
			end
			ocount_q <= ocount_q + {1'b0, rd_s1} - {1'b0, opop};
		end
	end

endmodule : sfrsc_back
`default_nettype wire

// ----- sim/tb_sync_frame_receiver_sum_check_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_frame_receiver_sum_check_unit
// Self-checking bench for the fixed-length frame receiver: a hand-written
// byte table followed by random frames under four idle and stall mixes.
// Every frame beat is checked against a cycle-free receiver model or the byte table.
// ----------------------------------------------------------------------------
module tb_sync_frame_receiver_sum_check_unit;
	import sfrsc_pkg::*;

	localparam int FRAME_LEN     = 16;
	localparam int DIR_ROWS      = 36;
	localparam int PHASE_ITEMS   = 16;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 200000;

	// How a directed row is checked: by the model, as "no beats" typed in,
	// or as "the last FRAME_LEN table bytes come back as one frame".
	typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_FRAME} row_check_t;

	typedef struct {
		logic [BYTE_W-1:0] rx_byte;
		row_check_t        check;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sfrsc_rx_if    rx_ch ();
	sfrsc_frame_if frame_ch ();
	sfrsc_cfg_if   cfg_ch ();

	sync_frame_receiver_sum_check_unit #(
		.FRAME_LEN(FRAME_LEN)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.frame (frame_ch),
		.cfg   (cfg_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Receiver model: its own copy of the start byte and frame state
	// ------------------------------------------------------------------
	logic [BYTE_W-1:0] m_start;
	logic              m_in_frame;
	int                m_fill;
	logic [BYTE_W-1:0] m_sum;
	logic [BYTE_W-1:0] m_store [FRAME_LEN];

	frame_beat_t       model_beats [FRAME_LEN];
	frame_beat_t       typed_frame [FRAME_LEN];
	frame_beat_t       pending_beats [$];

	stim_row_t         dir_tab [DIR_ROWS];

	int                idle_pct;
	int                stall_pct;
	int                frame_items;
	int                mismatch_count;
	int unsigned       cycle_count;

	// Advance the model by one received byte; return the number of frame
	// beats it releases (FRAME_LEN on a good checksum, else 0).
	function automatic int rx_frame_predict(input logic [BYTE_W-1:0] b);
		int n;
		int k;
		n = 0;
		if (!m_in_frame) begin
			// hunting: drop everything but the start byte
			if (b != m_start)
				return 0;
			m_in_frame = 1'b1;
			m_fill     = 0;
			m_sum      = '0;
		end
		m_store[m_fill] = b;
		if (m_fill + 1 < FRAME_LEN) begin
			m_sum  = m_sum + b;
			m_fill = m_fill + 1;
			return 0;
		end
		// b is the checksum byte
		if (m_sum == b) begin
			for (k = 0; k < FRAME_LEN; k++)
				model_beats[k] = '{frame_byte: m_store[k], byte_index: INDEX_W'(k),
					frame_last: (k == FRAME_LEN - 1)};
			n = FRAME_LEN;
		end
		m_in_frame = 1'b0;
		m_fill     = 0;
		m_sum      = '0;
		return n;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one rx beat, hold it until taken, then queue what it should cause.
	// Valid stays high into the next call unless an idle cycle drops it.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input row_check_t check);
		int n;
		int k;
		while ($urandom_range(99) < idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (rx_ch.ready !== 1'b1);
		n = rx_frame_predict(b);
		if (check == CHK_PRED) begin
			for (k = 0; k < n; k++)
				pending_beats.push_back(model_beats[k]);
		end else if (check == CHK_FRAME) begin
			for (k = 0; k < FRAME_LEN; k++)
				pending_beats.push_back(typed_frame[k]);
		end
	endtask

	// Write the start byte register; rx is held off whenever this runs.
	task automatic write_start_byte(input logic [BYTE_W-1:0] v);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.start_byte <= v;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		m_start = v;
	endtask

	// Hold off rx until every queued beat is back, then give a dropped frame
	// still in flight time to finish.
	task automatic settle();
		rx_ch.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random sequence: mostly good frames, some with a bad checksum,
	// a few cut short, and bursts of line noise the hunter must drop.
	task automatic send_random_seq();
		logic [BYTE_W-1:0] body [FRAME_LEN];
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] sum;
		int kind;
		int n;
		int k;
		kind = $urandom_range(99);
		if (kind < 15) begin
			n = $urandom_range(4, 1);
			for (k = 0; k < n; k++) begin
				b = 8'($urandom);
				while (b == m_start)
					b = 8'($urandom);
				send_byte(b, CHK_PRED);
			end
		end else begin
			// truncated frames merge with the next one and shift alignment
			n = (kind < 20) ? $urandom_range(FRAME_LEN - 2, 2) : FRAME_LEN;
			body[0] = m_start;
			sum     = m_start;
			for (k = 1; k < FRAME_LEN - 1; k++) begin
				// start byte as payload now and then: must not restart the frame
				body[k] = ($urandom_range(9) == 0) ? m_start : 8'($urandom);
				sum     = sum + body[k];
			end
			body[FRAME_LEN-1] = (kind < 35) ? sum + 8'($urandom_range(255, 1)) : sum;
			for (k = 0; k < n; k++)
				send_byte(body[k], CHK_PRED);
			frame_items += n;
		end
	endtask

	// Receiver side: stall at the rate of the current phase.
	always @(posedge clk)
		frame_ch.ready <= ($urandom_range(99) >= stall_pct);

	// ------------------------------------------------------------------
	// Beat checker: every accepted frame beat against the oldest expected
	// ------------------------------------------------------------------
	always @(posedge clk) begin : beat_check
		frame_beat_t want;
		if (arst_n === 1'b1 && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual byte %02h index %0d last %0b",
					$time, frame_ch.frame_byte, frame_ch.byte_index, frame_ch.frame_last);
				mismatch_count++;
			end else begin
				want = pending_beats.pop_front();
				if (frame_ch.frame_byte !== want.frame_byte) begin
					$display("%0t: frame_byte mismatch, expected %02h actual %02h",
						$time, want.frame_byte, frame_ch.frame_byte);
					mismatch_count++;
				end
				if (frame_ch.byte_index !== want.byte_index) begin
					$display("%0t: byte_index mismatch, expected %0d actual %0d",
						$time, want.byte_index, frame_ch.byte_index);
					mismatch_count++;
				end
				if (frame_ch.frame_last !== want.frame_last) begin
					$display("%0t: frame_last mismatch, expected %0b actual %0b",
						$time, want.frame_last, frame_ch.frame_last);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: fail and end the run once the cycle limit is reached.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("sync_frame_receiver_sum_check_unit regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [BYTE_W-1:0] start_tab [4];
		int                idle_tab [4];
		int                stall_tab [4];
		int                row;
		int                ph;
		int                k;

		// every input known from time zero
		arst_n            = 1'b0;
		rx_ch.valid       = 1'b0;
		rx_ch.rx_byte     = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.start_byte = '0;
		frame_ch.ready    = 1'b0;
		idle_pct          = 0;
		stall_pct         = 0;
		mismatch_count    = 0;
		frame_items       = 0;

		m_start    = START_RESET;
		m_in_frame = 1'b0;
		m_fill     = 0;
		m_sum      = '0;

		// Random phases: start byte and idle / stall mix of each.
		// The last start byte is drawn at random.
		start_tab = '{8'hAA, 8'h00, 8'hFF, 8'h00};
		idle_tab  = '{0, 79, 0, 6};
		stall_tab = '{0, 0, 79, 6};

		// Directed rows, start byte at its reset value 0xC1.
		dir_tab = '{
			// hunting: noise is dropped
			'{8'h00, CHK_NONE}, '{8'hC0, CHK_PRED},
			// good frame: byte extremes, start byte repeated as payload,
			// checksum C1+FF+C1+FF wraps to 80
			'{8'hC1, CHK_NONE}, '{8'hFF, CHK_NONE}, '{8'h00, CHK_NONE},
			'{8'hC1, CHK_NONE}, '{8'hFF, CHK_NONE},
			'{8'h00, CHK_NONE}, '{8'h00, CHK_NONE}, '{8'h00, CHK_NONE},
			'{8'h00, CHK_NONE}, '{8'h00, CHK_NONE}, '{8'h00, CHK_NONE},
			'{8'h00, CHK_NONE}, '{8'h00, CHK_NONE}, '{8'h00, CHK_NONE},
			'{8'h00, CHK_NONE},
			'{8'h80, CHK_FRAME},
			// bad frame: sum is 82, checksum 83, whole frame dropped and
			// the inner start byte is not hunted for
			'{8'hC1, CHK_NONE}, '{8'h00, CHK_NONE}, '{8'hC1, CHK_NONE},
			'{8'h00, CHK_NONE}, '{8'h00, CHK_NONE}, '{8'h00, CHK_NONE},
			'{8'h00, CHK_NONE}, '{8'h00, CHK_NONE}, '{8'h00, CHK_NONE},
			'{8'h00, CHK_NONE}, '{8'h00, CHK_NONE}, '{8'h00, CHK_NONE},
			'{8'h00, CHK_NONE}, '{8'h00, CHK_NONE}, '{8'h00, CHK_NONE},
			'{8'h83, CHK_NONE},
			// back to hunting
			'{8'h00, CHK_NONE}, '{8'h7F, CHK_PRED}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling on either side.
		for (row = 0; row < DIR_ROWS; row++) begin
			if (dir_tab[row].check == CHK_FRAME) begin
				// read the expected frame straight off the table
				for (k = 0; k < FRAME_LEN; k++)
					typed_frame[k] = '{frame_byte: dir_tab[row-FRAME_LEN+1+k].rx_byte,
						byte_index: INDEX_W'(k), frame_last: (k == FRAME_LEN - 1)};
			end
			send_byte(dir_tab[row].rx_byte, dir_tab[row].check);
		end

		// Random part: drain, change the start byte, then run the phase.
		for (ph = 0; ph < 4; ph++) begin
			settle();
			write_start_byte((ph == 3) ? 8'($urandom) : start_tab[ph]);
			idle_pct     = idle_tab[ph];
			stall_pct   <= stall_tab[ph];
			frame_items  = 0;
			while (frame_items < PHASE_ITEMS)
				send_random_seq();
		end

		// Drain with the receiver always ready, then report.
		stall_pct <= 0;
		settle();
		if (mismatch_count == 0)
			$display("sync_frame_receiver_sum_check_unit regression: pass");
		else
			$display("sync_frame_receiver_sum_check_unit regression: fail");
		$finish;
	end

endmodule : tb_sync_frame_receiver_sum_check_unit

// ----- filelist.f -----
rtl/sfrsc_pkg.sv
rtl/sfrsc_if.sv
rtl/sfrsc_ram.sv
rtl/sfrsc_front.sv
rtl/sfrsc_queue.sv
rtl/sfrsc_back.sv
rtl/sync_frame_receiver_sum_check_unit.sv
sim/tb_sync_frame_receiver_sum_check_unit.sv
